// ----- hdl/gtg_pkg.sv -----
// Shared types, constants and arithmetic steps of the go-to-goal controller.
package gtg_pkg;

   localparam int CORDIC_STEPS = 17;
   localparam int SQRT_STEPS = 33;
   localparam int PRESCALE = 20;
   localparam int CW = 56;
   localparam int ZW = 20;
   localparam int EW = 21;

   localparam logic signed [ZW-1:0] PI_Z = 20'sd205887;
   localparam logic signed [EW-1:0] PI_E = 21'sd205887;
   localparam logic signed [EW-1:0] TWO_PI_E = 21'sd411774;

   localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
      20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
      20'sd8, 20'sd4, 20'sd2, 20'sd1
   };

   localparam logic [2:0] REG_GOAL_X = 3'd0;
   localparam logic [2:0] REG_GOAL_Y = 3'd1;
   localparam logic [2:0] REG_GAIN_DIST = 3'd2;
   localparam logic [2:0] REG_GAIN_HEAD = 3'd3;
   localparam logic [2:0] REG_DIST_TOL = 3'd4;
   localparam logic [2:0] REG_LIN_LIMIT = 3'd5;
   localparam logic [2:0] REG_ANG_LIMIT = 3'd6;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic zero;
   } cordic_type;

   typedef struct packed {
      logic valid;
      cordic_type yaw;
      cordic_type brg;
      logic [65:0] rad;
      logic [36:0] rem;
      logic [32:0] root;
      logic signed [EW-1:0] err;
   } core_type;

   typedef struct packed {
      logic [15:0] gain_dist;
      logic [15:0] gain_head;
      logic [30:0] dist_tol;
      logic [30:0] lin_limit;
      logic [30:0] ang_limit;
   } cfg_type;

   function automatic cordic_type cordic_init(input logic signed [33:0] yi,
                                              input logic signed [33:0] xi);
      cordic_type r;
      logic signed [34:0] xn;
      logic signed [34:0] yn;
      r.zero = (xi == 34'sd0) && (yi == 34'sd0);
      if (xi < 0) begin
         r.z = (yi >= 0) ? PI_Z : -PI_Z;
         xn = -35'(xi);
         yn = -35'(yi);
      end else begin
         r.z = '0;
         xn = 35'(xi);
         yn = 35'(yi);
      end
      r.x = CW'(xn) <<< PRESCALE;
      r.y = CW'(yn) <<< PRESCALE;
      return r;
   endfunction

   function automatic cordic_type cordic_iter(input cordic_type c, input int i);
      cordic_type r;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      r = c;
      xs = c.x >>> i;
      ys = c.y >>> i;
      if (c.y > 0) begin
         r.x = c.x + ys;
         r.y = c.y - xs;
         r.z = c.z + ATAN_TAB[i];
      end else begin
         r.x = c.x - ys;
         r.y = c.y + xs;
         r.z = c.z - ATAN_TAB[i];
      end
      return r;
   endfunction

   function automatic logic signed [EW-1:0] wrap_err(input cordic_type yaw,
                                                      input cordic_type brg);
      logic signed [EW-1:0] a;
      logic signed [EW-1:0] b;
      logic signed [EW-1:0] e;
      a = yaw.zero ? '0 : EW'(yaw.z);
      b = brg.zero ? '0 : EW'(brg.z);
      e = b - a;
      if (e > PI_E) begin
         e = e - TWO_PI_E;
      end else if (e < -PI_E) begin
         e = e + TWO_PI_E;
      end
      return e;
   endfunction

   function automatic core_type core_step(input core_type s, input int j);
      core_type r;
      logic [36:0] rem_n;
      logic [36:0] trial;
      r = s;
      if (j < CORDIC_STEPS) begin
         r.yaw = cordic_iter(s.yaw, j);
         r.brg = cordic_iter(s.brg, j);
      end
      if (j == CORDIC_STEPS) begin
         r.err = wrap_err(s.yaw, s.brg);
      end
      rem_n = {s.rem[34:0], s.rad[65:64]};
      trial = {2'b00, s.root, 2'b01};
      if (rem_n >= trial) begin
         r.rem = rem_n - trial;
         r.root = {s.root[31:0], 1'b1};
      end else begin
         r.rem = rem_n;
         r.root = {s.root[31:0], 1'b0};
      end
      r.rad = {s.rad[63:0], 2'b00};
      return r;
   endfunction

endpackage

// ----- hdl/gtg_prep.sv -----
// Front stages: goal offsets, quaternion products, squares and CORDIC setup.
module gtg_prep (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic in_valid,
   input logic signed [31:0] goal_x,
   input logic signed [31:0] goal_y,
   input logic signed [31:0] pos_x,
   input logic signed [31:0] pos_y,
   input logic signed [15:0] quat_w,
   input logic signed [15:0] quat_x,
   input logic signed [15:0] quat_y,
   input logic signed [15:0] quat_z,
   output gtg_pkg::core_type out
);

   logic s1_valid_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [31:0] p_wz_ff, p_xy_ff, p_ww_ff, p_xx_ff, p_yy_ff, p_zz_ff;

   logic s2_valid_ff;
   gtg_pkg::cordic_type yaw2_ff, brg2_ff;
   logic [33:0] hh_x_ff, hh_y_ff;
   logic [32:0] hl_x_ff, hl_y_ff;
   logic [31:0] ll_x_ff, ll_y_ff;

   logic s3_valid_ff;
   gtg_pkg::cordic_type yaw3_ff, brg3_ff;
   logic [65:0] rad_ff;

   logic signed [33:0] qy_in, qx_in;
   logic [32:0] ax_in, ay_in;
   logic [65:0] rad_in;

   always_comb begin
      qy_in = 34'(p_wz_ff) + 34'(p_xy_ff);
      qy_in = qy_in <<< 1;
      qx_in = 34'(p_ww_ff) + 34'(p_xx_ff) - 34'(p_yy_ff) - 34'(p_zz_ff);
      ax_in = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      ay_in = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
      rad_in = ({32'd0, hh_x_ff} << 32) + ({33'd0, hl_x_ff} << 17) + 66'(ll_x_ff)
             + ({32'd0, hh_y_ff} << 32) + ({33'd0, hl_y_ff} << 17) + 66'(ll_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         dx_ff <= 33'(goal_x) - 33'(pos_x);
         dy_ff <= 33'(goal_y) - 33'(pos_y);
         p_wz_ff <= quat_w * quat_z;
         p_xy_ff <= quat_x * quat_y;
         p_ww_ff <= quat_w * quat_w;
         p_xx_ff <= quat_x * quat_x;
         p_yy_ff <= quat_y * quat_y;
         p_zz_ff <= quat_z * quat_z;

         s2_valid_ff <= s1_valid_ff;
         yaw2_ff <= gtg_pkg::cordic_init(qy_in, qx_in);
         brg2_ff <= gtg_pkg::cordic_init(34'(dy_ff), 34'(dx_ff));
         hh_x_ff <= ax_in[32:16] * ax_in[32:16];
         hl_x_ff <= ax_in[32:16] * ax_in[15:0];
         ll_x_ff <= ax_in[15:0] * ax_in[15:0];
         hh_y_ff <= ay_in[32:16] * ay_in[32:16];
         hl_y_ff <= ay_in[32:16] * ay_in[15:0];
         ll_y_ff <= ay_in[15:0] * ay_in[15:0];

         s3_valid_ff <= s2_valid_ff;
         yaw3_ff <= yaw2_ff;
         brg3_ff <= brg2_ff;
         rad_ff <= rad_in;
      end
   end

   always_comb begin
      out.valid = s3_valid_ff;
      out.yaw = yaw3_ff;
      out.brg = brg3_ff;
      out.rad = rad_ff;
      out.rem = '0;
      out.root = '0;
      out.err = '0;
   end

endmodule

// ----- hdl/gtg_core.sv -----
// Iteration pipeline: two CORDIC vectoring units and a digit-by-digit square root.
module gtg_core (
   input logic clock,
   input logic reset,
   input logic advance,
   input gtg_pkg::core_type in,
   output gtg_pkg::core_type out
);

   gtg_pkg::core_type st_ff [gtg_pkg::SQRT_STEPS];
   gtg_pkg::core_type st_in [gtg_pkg::SQRT_STEPS];

   for (genvar j = 0; j < gtg_pkg::SQRT_STEPS; j++) begin : g_stage
      if (j == 0) begin : g_first
         always_comb st_in[j] = gtg_pkg::core_step(in, j);
      end else begin : g_next
         always_comb st_in[j] = gtg_pkg::core_step(st_ff[j-1], j);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[j].valid <= 1'b0;
         end else if (advance) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   assign out = st_ff[gtg_pkg::SQRT_STEPS-1];

endmodule

// ----- hdl/gtg_out.sv -----
// Output stages: gain products, goal test, zeroing, clamping and the result register.
module gtg_out (
   input logic clock,
   input logic reset,
   input logic advance,
   input gtg_pkg::core_type in,
   input gtg_pkg::cfg_type cfg,
   output logic out_valid,
   output logic signed [31:0] lin_vel,
   output logic signed [31:0] ang_vel,
   output logic at_goal
);

   logic a_valid_ff;
   logic [48:0] lin_p_ff;
   logic signed [37:0] ang_p_ff;
   logic at_ff;

   logic valid_ff;
   logic signed [31:0] lin_ff, ang_ff;
   logic goal_ff;

   logic [40:0] lin_s;
   logic signed [31:0] ang_s;
   logic signed [31:0] lim_a;
   logic signed [31:0] lin_in, ang_in;

   always_comb begin
      lin_s = lin_p_ff[48:8];
      ang_s = 32'($signed(ang_p_ff[37:8]));
      lim_a = $signed({1'b0, cfg.ang_limit});
      if (at_ff) begin
         lin_s = '0;
         ang_s = '0;
      end
      if (lin_s > {10'd0, cfg.lin_limit}) begin
         lin_in = $signed({1'b0, cfg.lin_limit});
      end else begin
         lin_in = $signed(lin_s[31:0]);
      end
      if (ang_s > lim_a) begin
         ang_in = lim_a;
      end else if (ang_s < -lim_a) begin
         ang_in = -lim_a;
      end else begin
         ang_in = ang_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in.valid;
         lin_p_ff <= 49'(cfg.gain_dist) * 49'(in.root);
         ang_p_ff <= 38'($signed({1'b0, cfg.gain_head})) * 38'(in.err);
         at_ff <= in.root < {2'b00, cfg.dist_tol};
         valid_ff <= a_valid_ff;
         lin_ff <= lin_in;
         ang_ff <= ang_in;
         goal_ff <= at_ff;
      end
   end

   assign out_valid = valid_ff;
   assign lin_vel = lin_ff;
   assign ang_vel = ang_ff;
   assign at_goal = goal_ff;

endmodule

// ----- hdl/go_to_goal_position_controller.sv -----
// Top level of the go-to-goal proportional controller with its register port.
//
// One request carries a pose: position in Q16.16 and an orientation
// quaternion in Q1.15. One response per request carries the linear and
// angular speed commands in Q16.16 and the at-goal flag.
// Goal, gains, tolerance and limits are set through the register port; the
// user must write them only while the block is idle, which the block does not
// itself enforce. Register i lies at byte address 4*i. The block takes a
// request in every cycle unless req_stall is high. Its depth is set by the 33
// square root steps, which run alongside the 17 CORDIC steps of both angles.
// All stages move together: while a response waits under stall, the whole
// pipeline holds and req_stall is high; nothing is lost or repeated.
// Reset empties the pipeline and clears all port registers to zero.
module go_to_goal_position_controller (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic signed [31:0] req_pos_x,
   input logic signed [31:0] req_pos_y,
   input logic signed [15:0] req_quat_w,
   input logic signed [15:0] req_quat_x,
   input logic signed [15:0] req_quat_y,
   input logic signed [15:0] req_quat_z,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic signed [31:0] rsp_lin_vel,
   output logic signed [31:0] rsp_ang_vel,
   output logic rsp_at_goal,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [4:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   logic signed [31:0] goal_x_ff, goal_y_ff;
   logic [15:0] gain_dist_ff, gain_head_ff;
   logic [30:0] dist_tol_ff, lin_limit_ff, ang_limit_ff;
   logic advance;
   logic wr_en;
   logic [2:0] reg_idx;
   gtg_pkg::cfg_type cfg;
   gtg_pkg::core_type prep_q, core_q;

   assign advance = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[4:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         gain_dist_ff <= '0;
         gain_head_ff <= '0;
         dist_tol_ff <= '0;
         lin_limit_ff <= '0;
         ang_limit_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            gtg_pkg::REG_GOAL_X: goal_x_ff <= csr_pwdata;
            gtg_pkg::REG_GOAL_Y: goal_y_ff <= csr_pwdata;
            gtg_pkg::REG_GAIN_DIST: gain_dist_ff <= csr_pwdata[15:0];
            gtg_pkg::REG_GAIN_HEAD: gain_head_ff <= csr_pwdata[15:0];
            gtg_pkg::REG_DIST_TOL: dist_tol_ff <= csr_pwdata[30:0];
            gtg_pkg::REG_LIN_LIMIT: lin_limit_ff <= csr_pwdata[30:0];
            gtg_pkg::REG_ANG_LIMIT: ang_limit_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         gtg_pkg::REG_GOAL_X: csr_prdata = goal_x_ff;
         gtg_pkg::REG_GOAL_Y: csr_prdata = goal_y_ff;
         gtg_pkg::REG_GAIN_DIST: csr_prdata = {16'd0, gain_dist_ff};
         gtg_pkg::REG_GAIN_HEAD: csr_prdata = {16'd0, gain_head_ff};
         gtg_pkg::REG_DIST_TOL: csr_prdata = {1'b0, dist_tol_ff};
         gtg_pkg::REG_LIN_LIMIT: csr_prdata = {1'b0, lin_limit_ff};
         gtg_pkg::REG_ANG_LIMIT: csr_prdata = {1'b0, ang_limit_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.gain_dist = gain_dist_ff;
      cfg.gain_head = gain_head_ff;
      cfg.dist_tol = dist_tol_ff;
      cfg.lin_limit = lin_limit_ff;
      cfg.ang_limit = ang_limit_ff;
   end

   gtg_prep u_prep (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(req_valid),
      .goal_x(goal_x_ff), .goal_y(goal_y_ff),
      .pos_x(req_pos_x), .pos_y(req_pos_y),
      .quat_w(req_quat_w), .quat_x(req_quat_x),
      .quat_y(req_quat_y), .quat_z(req_quat_z),
      .out(prep_q)
   );

   gtg_core u_core (
      .clock(clock), .reset(reset), .advance(advance), .in(prep_q), .out(core_q)
   );

   gtg_out u_out (
      .clock(clock), .reset(reset), .advance(advance), .in(core_q), .cfg(cfg),
      .out_valid(rsp_valid), .lin_vel(rsp_lin_vel), .ang_vel(rsp_ang_vel),
      .at_goal(rsp_at_goal)
   );

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall) else $error("pipeline moved under stall");
   a_goal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_goal |-> rsp_lin_vel == 32'sd0 && rsp_ang_vel == 32'sd0)
      else $error("at goal with nonzero command");
   a_lin_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_lin_vel[31]) else $error("negative linear speed");
   a_ang_lim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ang_vel[31] |-> rsp_ang_vel[30:0] <= ang_limit_ff)
      else $error("angular speed over limit");
`endif

endmodule
